### hw/rtl/sdct_pkg.sv
// Shared types, register codes and default parameters of the SysTick-style down-counter timer.
package sdct_pkg;

  localparam int unsigned DefCountWidth  = 24;
  localparam int unsigned DefPrescaleDiv = 8;
  localparam int unsigned DataWidth      = 32;

  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindRead  = 2'd1,
    KindWrite = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RegCtrl    = 2'd0,
    RegLoad    = 2'd1,
    RegVal     = 2'd2,
    RegElapsed = 2'd3
  } reg_addr_e;

  // CTRL bit positions
  localparam int unsigned CtrlEnableBit   = 0;
  localparam int unsigned CtrlTickIntBit  = 1;
  localparam int unsigned CtrlClkSrcBit   = 2;
  localparam int unsigned CtrlOneShotBit  = 3;
  localparam int unsigned CtrlCountFlagBit = 16;

endpackage

### hw/rtl/systick_down_counter_timer_top.sv
// Reloading down-counter timer with CTRL/LOAD/VAL/ELAPSED registers.
//
// Input channel (in_valid_i/in_ready_o) carries one transaction per cycle when not stalled:
// a clock tick, a register read or a register write, selected by kind_i.
// Every input transaction yields exactly one output transaction on
// out_valid_o/out_ready_i with read_data_o, irq_pulse_o and load_rejected_o.
// Reads return register contents, ticks and writes return zero read data.
//
// The timer state and the result register update at the edge that accepts the
// input. Throughput is one transaction per cycle unless the receiver stalls,
// set by the single output register; in_ready_o is high whenever that register is
// empty or is being drained in the same cycle.
//
// When the receiver stalls, the result holds in the output register and
// in_ready_o drops until it is taken, so ticks are never dropped inside the
// block. Reset clears all control bits, COUNTFLAG, the reload value, the count
// and the prescaler, and empties the output register.
module systick_down_counter_timer_top
  import sdct_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH  = DefCountWidth,
  parameter int unsigned PRESCALE_DIV = DefPrescaleDiv
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic [1:0]           reg_addr_i,
  input  logic [DataWidth-1:0] write_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DataWidth-1:0] read_data_o,
  output logic                 irq_pulse_o,
  output logic                 load_rejected_o
);

  localparam int unsigned PreWidth = (PRESCALE_DIV > 1) ? $clog2(PRESCALE_DIV) : 1;
  localparam logic [PreWidth-1:0] PreLast = PreWidth'(PRESCALE_DIV - 1);
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  logic                   enable_q, enable_d;
  logic                   tick_int_q, tick_int_d;
  logic                   clk_undiv_q, clk_undiv_d;
  logic                   one_shot_q, one_shot_d;
  logic                   flag_q, flag_d;
  logic [COUNT_WIDTH-1:0] reload_q, reload_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [PreWidth-1:0]    pre_q, pre_d;

  logic                   out_valid_q;
  logic [DataWidth-1:0]   rdata_q, rdata_d;
  logic                   irq_q, irq_d;
  logic                   rej_q, rej_d;

  logic                   in_accept;
  logic                   step;
  logic                   load_too_big;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign load_too_big = ((33'(write_data_i) >> COUNT_WIDTH) != 33'd0);

  always_comb begin
    enable_d    = enable_q;
    tick_int_d  = tick_int_q;
    clk_undiv_d = clk_undiv_q;
    one_shot_d  = one_shot_q;
    flag_d      = flag_q;
    reload_d    = reload_q;
    count_d     = count_q;
    pre_d       = pre_q;
    rdata_d     = '0;
    irq_d       = 1'b0;
    rej_d       = 1'b0;
    step        = 1'b0;

    unique case (kind_i)
      KindTick: begin
        if (enable_q) begin
          if (clk_undiv_q) begin
            step = 1'b1;
          end else if (pre_q >= PreLast) begin
            pre_d = '0;
            step  = 1'b1;
          end else begin
            pre_d = pre_q + PreWidth'(1);
          end
        end
      end
      KindRead: begin
        unique case (reg_addr_i)
          RegCtrl: begin
            rdata_d[CtrlEnableBit]    = enable_q;
            rdata_d[CtrlTickIntBit]   = tick_int_q;
            rdata_d[CtrlClkSrcBit]    = clk_undiv_q;
            rdata_d[CtrlOneShotBit]   = one_shot_q;
            rdata_d[CtrlCountFlagBit] = flag_q;
            flag_d = 1'b0;
          end
          RegLoad:    rdata_d = DataWidth'(reload_q);
          RegVal:     rdata_d = DataWidth'(count_q);
          RegElapsed: rdata_d = DataWidth'(reload_q) - DataWidth'(count_q);
          default:    rdata_d = '0;
        endcase
      end
      KindWrite: begin
        unique case (reg_addr_i)
          RegCtrl: begin
            enable_d    = write_data_i[CtrlEnableBit];
            tick_int_d  = write_data_i[CtrlTickIntBit];
            clk_undiv_d = write_data_i[CtrlClkSrcBit];
            one_shot_d  = write_data_i[CtrlOneShotBit];
          end
          RegLoad: begin
            if (load_too_big) begin
              rej_d = 1'b1;
            end else begin
              reload_d = write_data_i[COUNT_WIDTH-1:0];
            end
          end
          RegVal: begin
            count_d = '0;
            flag_d  = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // a step from zero reloads; a decrement landing on zero expires
    if (step) begin
      if (count_q == '0) begin
        count_d = reload_q;
      end else begin
        count_d = count_q - CountOne;
        if (count_q == CountOne) begin
          flag_d = 1'b1;
          irq_d  = tick_int_q;
          if (one_shot_q) begin
            enable_d   = 1'b0;
            tick_int_d = 1'b0;
            reload_d   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      tick_int_q  <= 1'b0;
      clk_undiv_q <= 1'b0;
      one_shot_q  <= 1'b0;
      flag_q      <= 1'b0;
      reload_q    <= '0;
      count_q     <= '0;
      pre_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        enable_q    <= enable_d;
        tick_int_q  <= tick_int_d;
        clk_undiv_q <= clk_undiv_d;
        one_shot_q  <= one_shot_d;
        flag_q      <= flag_d;
        reload_q    <= reload_d;
        count_q     <= count_d;
        pre_q       <= pre_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
      rej_q   <= rej_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rdata_q;
  assign irq_pulse_o     = irq_q;
  assign load_rejected_o = rej_q;

`ifndef ASSERT_OFF
  // a held result must block new input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while result stalled");

  // an interrupt comes only from an expiry: count zero and flag set afterwards
  a_irq_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && irq_d |=> count_q == '0 && flag_q)
    else $error("irq without expiry");

  // a VAL write clears the count and COUNTFLAG
  a_val_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && kind_i == KindWrite && reg_addr_i == RegVal |=> count_q == '0 && !flag_q)
    else $error("VAL write did not clear");

  // interrupts and rejections never carry read data
  a_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (irq_pulse_o || load_rejected_o) |-> read_data_o == '0)
    else $error("read data on tick or write result");
`endif

endmodule
